/* hw/rtl/lrd_pkg.sv */
// Shared constants and command codes of the LED ramp dimmer.
package lrd_pkg;

    localparam int CHANNELS_DEF   = 4;
    localparam int LEVEL_BITS_DEF = 13;
    localparam int ACC_W          = 17;
    localparam int RLEN_W         = 16;
    localparam int RELOAD_W       = 16;
    localparam int TPS_W          = 7;
    localparam int SECS_W         = 12;
    localparam int CFG_IDX_W      = 2;

    localparam logic [RELOAD_W-1:0] RELOAD_RST = 16'd600;
    localparam logic [TPS_W-1:0]    TPS_RST    = 7'd10;

    typedef enum logic [2:0] {
        MODE_TICK  = 3'd0,
        MODE_SET   = 3'd1,
        MODE_RAMP  = 3'd2,
        MODE_POWER = 3'd3,
        MODE_RAW   = 3'd4
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RELOAD = 2'd0,
        CFG_TPS    = 2'd1
    } t_cfg_idx;

endpackage

/* hw/rtl/led_ramp_dimmer_cubic_gamma.sv */
// LED ramp dimmer top level: channel state memory, step divider and cubic gamma.
// A raw-duty item goes through the read, execute and emit states; set, power and zero-length
// ramp items also pass the gamma multiply states MUL1 and MUL2; a ramp start gives no result.
// A tick visits every channel, stepping ramping channels through the bit-serial step divider
// when a step is due, then makes a status pass when one is due; a stalled output holds the item.
// One item is processed at a time; reset clears control state and channel valid bits.
module led_ramp_dimmer_cubic_gamma
    import lrd_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [2:0]            i_mode,
    input  logic [1:0]            i_channel,
    input  logic signed [15:0]    i_value,
    input  logic [SECS_W-1:0]     i_seconds,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_out_channel,
    output logic [LEVEL_BITS-1:0] o_duty,
    output logic                  o_is_status,
    output logic                  o_power_on,
    output logic [LEVEL_BITS-1:0] o_level,
    output logic                  o_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    localparam int LB = LEVEL_BITS;
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW = $clog2(ACC_W);
    localparam logic [LB-1:0] LMAX = {LB{1'b1}};

    typedef struct packed {
        logic [LB-1:0]     bright;
        logic [LB-1:0]     target;
        logic [RLEN_W-1:0] rlen;
        logic [ACC_W-1:0]  acc;
        logic [LB-1:0]     delta;
        logic              rising;
        logic              pow;
    } t_word;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RD   = 9'b000000010,
        S_EXEC = 9'b000000100,
        S_DIV  = 9'b000001000,
        S_FIN  = 9'b000010000,
        S_MUL1 = 9'b000100000,
        S_MUL2 = 9'b001000000,
        S_EMIT = 9'b010000000,
        S_NEXT = 9'b100000000
    } t_state;

    logic          r_end;
    t_state        r_state;
    logic [2:0]    r_mode;
    logic signed [15:0] r_val;
    logic [SECS_W-1:0] r_secs;
    logic [AW-1:0] r_addr;
    logic          r_phase;
    logic          r_do_status;
    logic [RELOAD_W-1:0] r_rpt;
    logic [RELOAD_W-1:0] r_reload;
    logic [TPS_W-1:0]    r_tps;

    t_word         mem [CHANNELS];
    logic [CHANNELS-1:0] r_vld;
    t_word         r_rdata;
    logic          r_rvld;
    t_word         r_w;
    logic [ACC_W-1:0] r_rem;
    logic [ACC_W-1:0] r_q;
    logic [CW-1:0] r_cnt;
    logic [LB-1:0] r_sq;
    logic [LB-1:0] r_duty;
    logic          r_isstat;

    logic          r_pv;
    logic [1:0]    r_pch;
    logic [LB-1:0] r_pduty;
    logic          r_pstat;
    logic          r_ppow;
    logic [LB-1:0] r_plev;

    logic          r_ov;
    logic [1:0]    r_och;
    logic [LB-1:0] r_oduty;
    logic          r_ostat;
    logic          r_opow;
    logic [LB-1:0] r_olev;
    logic          r_olast;

    t_word         w;
    t_word         set_w;
    t_word         ramp_w;
    t_word         pow_w;
    t_word         fin_w;
    t_word         wdata;
    logic          we;
    logic [LB-1:0] sat;
    logic [SECS_W+TPS_W-1:0] lenp;
    logic [RLEN_W-1:0] len16;
    logic [ACC_W-1:0]  acc_sum;
    logic [ACC_W-1:0]  len_x;
    logic [ACC_W-1:0]  div_t;
    logic signed [ACC_W+1:0] nb;
    logic          done;
    logic [2*LB-1:0] p1;
    logic [2*LB-1:0] p2;
    logic          out_free;
    logic          in_acc;
    logic          ch_ok;
    logic          last_ch;
    logic          to_status;
    logic          out_load;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_ov || !i_out_stall;
    assign ch_ok       = (32'(i_channel) < CHANNELS);

    assign last_ch   = r_end || r_mode != MODE_TICK || r_addr == AW'(CHANNELS - 1);
    assign to_status = !r_end && r_mode == MODE_TICK && !r_phase && r_do_status;
    assign out_load  = r_pv && out_free &&
                       ((r_state == S_EMIT) || (r_state == S_NEXT && last_ch && !to_status));

    assign o_out_valid   = r_ov;
    assign o_out_channel = r_och;
    assign o_duty        = r_oduty;
    assign o_is_status   = r_ostat;
    assign o_power_on    = r_opow;
    assign o_level       = r_olev;
    assign o_last        = r_olast;

    always_comb begin
        w = r_rvld ? r_rdata : '0;
        if (r_val < 0) begin
            sat = '0;
        end else if (int'(r_val) > int'(LMAX)) begin
            sat = LMAX;
        end else begin
            sat = LB'(r_val);
        end
        lenp  = (SECS_W + TPS_W)'(r_secs) * (SECS_W + TPS_W)'(r_tps);
        len16 = (lenp > (SECS_W + TPS_W)'({RLEN_W{1'b1}})) ? {RLEN_W{1'b1}} : lenp[RLEN_W-1:0];

        set_w        = w;
        set_w.bright = sat;
        set_w.target = sat;
        set_w.rlen   = '0;

        ramp_w        = w;
        ramp_w.rlen   = len16;
        ramp_w.target = sat;
        ramp_w.acc    = '0;
        ramp_w.rising = sat > w.bright;
        ramp_w.delta  = (sat > w.bright) ? sat - w.bright : w.bright - sat;

        pow_w     = w;
        pow_w.pow = (r_val != 0);

        acc_sum = w.acc + ACC_W'(w.delta);
        len_x   = ACC_W'(r_w.rlen);
        div_t   = {r_rem[ACC_W-2:0], r_q[ACC_W-1]};

        nb = r_w.rising ? $signed((ACC_W+2)'(r_w.bright)) + $signed((ACC_W+2)'(r_q))
                        : $signed((ACC_W+2)'(r_w.bright)) - $signed((ACC_W+2)'(r_q));
        done = r_w.rising ? (nb >= $signed((ACC_W+2)'(r_w.target)))
                          : (nb <= $signed((ACC_W+2)'(r_w.target)));
        fin_w        = r_w;
        fin_w.acc    = r_rem + ACC_W'(1);
        fin_w.bright = done ? r_w.target : nb[LB-1:0];
        fin_w.rlen   = done ? '0 : r_w.rlen;

        p1 = (2*LB)'(r_w.bright) * (2*LB)'(r_w.bright);
        p2 = (2*LB)'(r_sq) * (2*LB)'(r_w.bright);

        we    = 1'b0;
        wdata = fin_w;
        if (r_state == S_FIN) begin
            we = 1'b1;
        end else if (r_state == S_EXEC) begin
            case (r_mode)
                MODE_SET: begin
                    we    = 1'b1;
                    wdata = set_w;
                end
                MODE_RAMP: begin
                    if (len16 == '0) begin
                        we    = 1'b1;
                        wdata = set_w;
                    end else if (sat != w.bright) begin
                        we    = 1'b1;
                        wdata = ramp_w;
                    end
                end
                MODE_POWER: begin
                    we    = 1'b1;
                    wdata = pow_w;
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_addr] <= wdata;
        end
        r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vld    <= '0;
            r_rvld   <= 1'b0;
            r_rpt    <= '0;
            r_reload <= RELOAD_RST;
            r_tps    <= TPS_RST;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
            r_end    <= 1'b0;
        end else begin
            r_rvld <= r_vld[r_addr];
            if (we) begin
                r_vld[r_addr] <= 1'b1;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_RELOAD: r_reload <= i_cfg_data;
                    CFG_TPS:    r_tps    <= i_cfg_data[TPS_W-1:0];
                    default:    r_tps    <= r_tps;
                endcase
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_mode   <= i_mode;
                        r_val    <= i_value;
                        r_secs   <= i_seconds;
                        r_phase  <= 1'b0;
                        r_isstat <= 1'b0;
                        if (i_mode == MODE_TICK) begin
                            r_addr      <= '0;
                            r_do_status <= (r_rpt == '0);
                            r_rpt       <= (r_rpt == '0) ? r_reload : r_rpt - 1'b1;
                            r_state     <= S_RD;
                        end else if (i_mode <= MODE_RAW && ch_ok) begin
                            r_addr      <= AW'(i_channel);
                            r_do_status <= 1'b0;
                            r_state     <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    case (r_mode)
                        MODE_TICK: begin
                            r_w <= w;
                            if (r_phase) begin
                                r_isstat <= 1'b1;
                                r_state  <= S_MUL1;
                            end else if (w.rlen == '0) begin
                                r_state <= S_NEXT;
                            end else begin
                                r_cnt <= '0;
                                if (acc_sum > ACC_W'(w.rlen)) begin
                                    r_rem   <= '0;
                                    r_q     <= acc_sum - ACC_W'(1);
                                    r_state <= S_DIV;
                                end else begin
                                    r_rem   <= acc_sum - ACC_W'(1);
                                    r_q     <= '0;
                                    r_state <= S_FIN;
                                end
                            end
                        end
                        MODE_SET: begin
                            r_w     <= set_w;
                            r_rpt   <= '0;
                            r_state <= S_MUL1;
                        end
                        MODE_RAMP: begin
                            if (len16 == '0) begin
                                r_w     <= set_w;
                                r_rpt   <= '0;
                                r_state <= S_MUL1;
                            end else begin
                                r_w     <= w;
                                r_end   <= 1'b1;
                                r_state <= S_NEXT;
                            end
                        end
                        MODE_POWER: begin
                            r_w     <= pow_w;
                            r_rpt   <= '0;
                            r_state <= S_MUL1;
                        end
                        default: begin
                            r_w     <= w;
                            r_duty  <= sat;
                            r_state <= S_EMIT;
                        end
                    endcase
                end
                S_DIV: begin
                    if (div_t >= len_x) begin
                        r_rem <= div_t - len_x;
                        r_q   <= {r_q[ACC_W-2:0], 1'b1};
                    end else begin
                        r_rem <= div_t;
                        r_q   <= {r_q[ACC_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(ACC_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_w     <= fin_w;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_sq    <= p1[2*LB-1:LB];
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_duty  <= r_w.pow ? p2[2*LB-1:LB] : '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_pv || out_free) begin
                        if (r_pv) begin
                            r_och   <= r_pch;
                            r_oduty <= r_pduty;
                            r_ostat <= r_pstat;
                            r_opow  <= r_ppow;
                            r_olev  <= r_plev;
                            r_olast <= 1'b0;
                        end
                        r_pv    <= 1'b1;
                        r_pch   <= 2'(r_addr);
                        r_pduty <= r_duty;
                        r_pstat <= r_isstat;
                        r_ppow  <= r_w.pow;
                        r_plev  <= r_w.bright;
                        r_end   <= (r_mode != MODE_TICK);
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (last_ch) begin
                        if (to_status) begin
                            r_phase <= 1'b1;
                            r_addr  <= '0;
                            r_state <= S_RD;
                        end else if (!r_pv) begin
                            r_end   <= 1'b0;
                            r_state <= S_IDLE;
                        end else if (out_free) begin
                            r_och   <= r_pch;
                            r_oduty <= r_pduty;
                            r_ostat <= r_pstat;
                            r_opow  <= r_ppow;
                            r_olev  <= r_plev;
                            r_olast <= 1'b1;
                            r_pv    <= 1'b0;
                            r_end   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_end <= 1'b1;
                        end
                    end else begin
                        r_addr  <= r_addr + 1'b1;
                        r_state <= S_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
